[design/lfha_pkg.sv]
// Package for the lowest-free handle allocator.
// Holds the operation codes, the field widths and the bitmap word geometry.
// No dependencies.
package lfha_pkg;

  localparam int DEFAULT_NUM_HANDLES = 256;
  localparam int HANDLE_W            = 8;
  localparam int HANDLE_SPAN         = 256;
  localparam int WORD_W              = 32;
  localparam int BIT_W               = 5;
  localparam int FUNC_W              = 2;

  localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FN_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_QUERY = 2'd2;
  localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd3;

  typedef struct packed {
    logic         we;
    logic [15:0]  waddr;
    logic [31:0]  wdata;
  } bm_wr_t;

endpackage

[design/lfha_bitmap.sv]
// Word-organized bitmap store of the allocator: one write port, one read port
// with registered read data. Depends on lfha_pkg.
module lfha_bitmap #(
  parameter int NUM_WORDS = 8,
  parameter int AW        = 3
) (
  input  logic                        clk_i,
  input  lfha_pkg::bm_wr_t            wr_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [lfha_pkg::WORD_W-1:0] rdata_o
);

  logic [lfha_pkg::WORD_W-1:0] mem [NUM_WORDS];
  logic [lfha_pkg::WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.waddr[AW-1:0]] <= wr_i.wdata;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/lowest_free_handle_allocator_top.sv]
// Top level of the lowest-free handle allocator: sequencer, word scan unit
// and output register. Depends on lfha_pkg and lfha_bitmap.
//
// channel  dir  signals                  beat
// s_*      in   tvalid tready tdata[15:0] func, handle_in
// m_*      out  tvalid tready tdata[15:0] handle_out, ok
//
// Free and query of an in-range handle read and evaluate its bitmap word.
// Allocate scans from word 0 up, at most ceil(min(NUM_HANDLES,256)/32) words.
// Clear zeroes every bitmap word, ceil(NUM_HANDLES/32) words in all.
// After reset the same sweep zeroes the store before the first beat is taken.
// A new beat is taken while a finished result waits on m_tready_i.
module lowest_free_handle_allocator_top #(
  parameter int NUM_HANDLES = lfha_pkg::DEFAULT_NUM_HANDLES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [15:0] s_tdata_i,   // [1:0] func, [9:2] handle_in, [15:10] zero
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [15:0] m_tdata_o    // [7:0] handle_out, [8] ok, [15:9] zero
);

  localparam int WW          = lfha_pkg::WORD_W;
  localparam int NUM_WORDS   = (NUM_HANDLES + WW - 1) / WW;
  localparam int AW          = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int ALLOC_LIM   = (NUM_HANDLES < lfha_pkg::HANDLE_SPAN) ?
                               NUM_HANDLES : lfha_pkg::HANDLE_SPAN;
  localparam int ALLOC_WORDS = (ALLOC_LIM + WW - 1) / WW;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EVAL  = 2'd1;
  localparam logic [1:0] S_CLEAR = 2'd2;
  localparam logic [1:0] S_PUSH  = 2'd3;

  logic [1:0]                        state_q, state_d;
  logic                              init_q, init_d;
  logic [AW-1:0]                     ctr_q, ctr_d;
  logic [lfha_pkg::FUNC_W-1:0]       func_q, func_d;
  logic [lfha_pkg::HANDLE_W-1:0]     hdl_q, hdl_d;
  logic [lfha_pkg::HANDLE_W-1:0]     res_hdl_q, res_hdl_d;
  logic                              res_ok_q, res_ok_d;
  logic                              m_valid_q, m_valid_d;
  logic [lfha_pkg::HANDLE_W-1:0]     m_hdl_q, m_hdl_d;
  logic                              m_ok_q, m_ok_d;

  logic [lfha_pkg::FUNC_W-1:0]       in_func;
  logic [lfha_pkg::HANDLE_W-1:0]     in_hdl;
  logic                              accept;
  logic                              in_range;
  logic [AW-1:0]                     in_word;
  logic [AW-1:0]                     raddr;
  logic [WW-1:0]                     rdata;
  lfha_pkg::bm_wr_t                  wr;

  logic [WW-1:0]                     valid_mask;
  logic [WW-1:0]                     free_bits;
  logic [WW-1:0]                     lowest_oh;
  logic [lfha_pkg::BIT_W-1:0]        lowest_idx;
  logic [AW+lfha_pkg::BIT_W-1:0]     grant_idx;
  logic [WW-1:0]                     hdl_oh;
  logic                              out_free;

  assign in_func    = s_tdata_i[1:0];
  assign in_hdl     = s_tdata_i[9:2];
  assign s_tready_o = (state_q == S_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;
  assign in_range   = (32'(in_hdl) < NUM_HANDLES);
  assign in_word    = AW'(32'(in_hdl) >> lfha_pkg::BIT_W);
  assign out_free   = !m_valid_q || m_tready_i;
  assign hdl_oh     = WW'(1) << hdl_q[lfha_pkg::BIT_W-1:0];

  // word scan: mask off bits past the grant limit, pick lowest zero
  always_comb begin
    for (int b = 0; b < WW; b++) begin
      valid_mask[b] = (32'({ctr_q, lfha_pkg::BIT_W'(b)}) < ALLOC_LIM);
    end
    free_bits  = ~rdata & valid_mask;
    lowest_oh  = free_bits & (~free_bits + WW'(1));
    lowest_idx = '0;
    for (int b = 0; b < WW; b++) begin
      if (lowest_oh[b]) begin
        lowest_idx = lowest_idx | lfha_pkg::BIT_W'(b);
      end
    end
    grant_idx = {ctr_q, lowest_idx};
  end

  always_comb begin
    state_d   = state_q;
    init_d    = init_q;
    ctr_d     = ctr_q;
    func_d    = func_q;
    hdl_d     = hdl_q;
    res_hdl_d = res_hdl_q;
    res_ok_d  = res_ok_q;
    m_valid_d = m_valid_q;
    m_hdl_d   = m_hdl_q;
    m_ok_d    = m_ok_q;
    raddr     = ctr_q;
    wr.we     = 1'b0;
    wr.waddr  = 16'(ctr_q);
    wr.wdata  = '0;

    if (m_valid_q && m_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          func_d    = in_func;
          hdl_d     = in_hdl;
          ctr_d     = '0;
          res_hdl_d = '0;
          res_ok_d  = 1'b0;
          unique case (in_func)
            lfha_pkg::FN_ALLOC: begin
              raddr   = '0;
              state_d = S_EVAL;
            end
            lfha_pkg::FN_FREE, lfha_pkg::FN_QUERY: begin
              raddr   = in_word;
              ctr_d   = in_word;
              state_d = in_range ? S_EVAL : S_PUSH;
            end
            default: begin
              state_d = S_CLEAR;
            end
          endcase
        end
      end
      S_EVAL: begin
        if (func_q == lfha_pkg::FN_ALLOC) begin
          priority if (free_bits != '0) begin
            wr.we     = 1'b1;
            wr.wdata  = rdata | lowest_oh;
            res_hdl_d = lfha_pkg::HANDLE_W'(grant_idx);
            res_ok_d  = 1'b1;
            state_d   = S_PUSH;
          end else if (ctr_q == AW'(ALLOC_WORDS - 1)) begin
            state_d = S_PUSH;
          end else begin
            ctr_d = ctr_q + 1'b1;
            raddr = ctr_q + 1'b1;
          end
        end else begin
          res_ok_d = |(rdata & hdl_oh);
          if (func_q == lfha_pkg::FN_FREE) begin
            wr.we    = 1'b1;
            wr.wdata = rdata & ~hdl_oh;
          end
          state_d = S_PUSH;
        end
      end
      S_CLEAR: begin
        wr.we = 1'b1;
        if (ctr_q == AW'(NUM_WORDS - 1)) begin
          ctr_d = '0;
          if (init_q) begin
            init_d  = 1'b0;
            state_d = S_IDLE;
          end else begin
            res_ok_d = 1'b1;
            state_d  = S_PUSH;
          end
        end else begin
          ctr_d = ctr_q + 1'b1;
        end
      end
      default: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_hdl_d   = res_hdl_q;
          m_ok_d    = res_ok_q;
          state_d   = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      init_q    <= 1'b1;
      ctr_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      init_q    <= init_d;
      ctr_q     <= ctr_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    hdl_q     <= hdl_d;
    res_hdl_q <= res_hdl_d;
    res_ok_q  <= res_ok_d;
    m_hdl_q   <= m_hdl_d;
    m_ok_q    <= m_ok_d;
  end

  lfha_bitmap #(
    .NUM_WORDS (NUM_WORDS),
    .AW        (AW)
  ) u_bitmap (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = {7'd0, m_ok_q, m_hdl_q};

endmodule

[dv/lowest_free_handle_allocator_top_test.sv]
// Testbench for lowest_free_handle_allocator_top: streams allocate, free, query and
// clear beats and checks every result beat against an in-bench bitmap predictor.
// Depends on lfha_pkg and the allocator RTL.
`timescale 1ns / 100ps

module lowest_free_handle_allocator_top_test;

  localparam int NUM_HANDLES = lfha_pkg::DEFAULT_NUM_HANDLES;
  localparam int GRANT_SPAN  = (NUM_HANDLES < lfha_pkg::HANDLE_SPAN) ?
                               NUM_HANDLES : lfha_pkg::HANDLE_SPAN;
  localparam int STALL_LIMIT = 4000;

  // result beat layout, lowest bit first: handle_out, ok, zero pad
  typedef struct packed {
    logic [6:0]                    pad;
    logic                          ok;
    logic [lfha_pkg::HANDLE_W-1:0] handle;
  } grant_t;

  class handle_scoreboard;
    bit     active [NUM_HANDLES];
    int     live;
    grant_t grant_q[$];
    int     errors, beats, grants, refusals, clears;

    function void note_beat(logic [lfha_pkg::FUNC_W-1:0] fn,
                            logic [lfha_pkg::HANDLE_W-1:0] h);
      grant_t g;
      int     slot;
      g = '0;
      slot = -1;
      beats++;
      case (fn)
        lfha_pkg::FN_ALLOC: begin
          for (int i = 0; i < GRANT_SPAN && slot < 0; i++)
            if (!active[i]) slot = i;
          if (slot >= 0) begin
            active[slot] = 1'b1;
            live++;
            g.handle = lfha_pkg::HANDLE_W'(slot);
            g.ok = 1'b1;
            grants++;
          end else begin
            refusals++;
          end
        end
        lfha_pkg::FN_FREE: begin
          if (h < NUM_HANDLES && active[h]) begin
            active[h] = 1'b0;
            live--;
            g.ok = 1'b1;
          end
        end
        lfha_pkg::FN_QUERY: begin
          g.ok = (h < NUM_HANDLES) && active[h];
        end
        default: begin
          foreach (active[i]) active[i] = 1'b0;
          live = 0;
          g.ok = 1'b1;
          clears++;
        end
      endcase
      grant_q = {grant_q, g};
    endfunction

    function void check_result(logic [15:0] data, time t);
      grant_t got;
      grant_t want;
      got = data;
      if (grant_q.size() == 0) begin
        $display("%0t: result beat %h with nothing expected", t, data);
        errors++;
        return;
      end
      want = grant_q.pop_front();
      if (got.handle !== want.handle) begin
        $display("%0t: handle_out expected %0d actual %0d", t, want.handle, got.handle);
        errors++;
      end
      if (got.ok !== want.ok) begin
        $display("%0t: ok expected %0b actual %0b", t, want.ok, got.ok);
        errors++;
      end
      if (got.pad !== want.pad) begin
        $display("%0t: pad bits expected %h actual %h", t, want.pad, got.pad);
        errors++;
      end
    endfunction

    function int pending();
      return grant_q.size();
    endfunction

    // random active handle, or a random one when none is active
    function logic [lfha_pkg::HANDLE_W-1:0] pick_active();
      int start;
      start = $urandom_range(NUM_HANDLES - 1);
      for (int i = 0; i < NUM_HANDLES; i++)
        if (active[(start + i) % NUM_HANDLES])
          return lfha_pkg::HANDLE_W'((start + i) % NUM_HANDLES);
      return lfha_pkg::HANDLE_W'(start);
    endfunction
  endclass

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  int src_idle = 16;
  int snk_idle = 69;
  int stall_cnt = 0;

  handle_scoreboard sb = new();

  lowest_free_handle_allocator_top #(
    .NUM_HANDLES(NUM_HANDLES)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid),
    .s_tready_o(s_tready),
    .s_tdata_i (s_tdata),
    .m_tvalid_o(m_tvalid),
    .m_tready_i(m_tready),
    .m_tdata_o (m_tdata)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= snk_idle);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) sb.check_result(m_tdata, $time);
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("lowest_free_handle_allocator_top regression: fail");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  function automatic logic [lfha_pkg::HANDLE_W-1:0] rand_handle();
    return lfha_pkg::HANDLE_W'($urandom_range(255));
  endfunction

  task automatic send_beat(input logic [lfha_pkg::FUNC_W-1:0] fn,
                           input logic [lfha_pkg::HANDLE_W-1:0] h);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, h, fn};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    sb.note_beat(fn, h);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic churn(input int count);
    int r;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 40)      send_beat(lfha_pkg::FN_ALLOC, rand_handle());
      else if (r < 62) send_beat(lfha_pkg::FN_FREE, sb.pick_active());
      else if (r < 70) send_beat(lfha_pkg::FN_FREE, rand_handle());
      else if (r < 84) send_beat(lfha_pkg::FN_QUERY, sb.pick_active());
      else if (r < 98) send_beat(lfha_pkg::FN_QUERY, rand_handle());
      else             send_beat(lfha_pkg::FN_CLEAR, rand_handle());
    end
  endtask

  // allocate until every handle is taken, hit the full store, then churn at full
  task automatic fill_store();
    while (sb.live < GRANT_SPAN) send_beat(lfha_pkg::FN_ALLOC, rand_handle());
    repeat (4) send_beat(lfha_pkg::FN_ALLOC, rand_handle());
    send_beat(lfha_pkg::FN_QUERY, 8'hff);
    repeat (12) begin
      send_beat(lfha_pkg::FN_FREE, sb.pick_active());
      send_beat(lfha_pkg::FN_ALLOC, rand_handle());
    end
    send_beat(lfha_pkg::FN_FREE, 8'hff);
    send_beat(lfha_pkg::FN_ALLOC, 8'h00);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_beat(lfha_pkg::FN_CLEAR, 8'hff);
    send_beat(lfha_pkg::FN_QUERY, 8'h00);
    send_beat(lfha_pkg::FN_QUERY, 8'hff);
    send_beat(lfha_pkg::FN_FREE,  8'h00);
    send_beat(lfha_pkg::FN_FREE,  8'hff);
    send_beat(lfha_pkg::FN_ALLOC, 8'haa);
    send_beat(lfha_pkg::FN_ALLOC, 8'h55);
    send_beat(lfha_pkg::FN_ALLOC, 8'hff);
    send_beat(lfha_pkg::FN_QUERY, 8'h01);
    send_beat(lfha_pkg::FN_FREE,  8'h00);
    send_beat(lfha_pkg::FN_QUERY, 8'h00);
    send_beat(lfha_pkg::FN_ALLOC, 8'h00);
    send_beat(lfha_pkg::FN_FREE,  8'h01);
    send_beat(lfha_pkg::FN_FREE,  8'h01);
    send_beat(lfha_pkg::FN_ALLOC, 8'h01);
    send_beat(lfha_pkg::FN_ALLOC, 8'h00);
    send_beat(lfha_pkg::FN_CLEAR, 8'h00);
    send_beat(lfha_pkg::FN_QUERY, 8'h02);
    send_beat(lfha_pkg::FN_ALLOC, 8'h00);
    send_beat(lfha_pkg::FN_CLEAR, 8'h5a);
    send_beat(lfha_pkg::FN_CLEAR, 8'ha5);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      src_idle = (phase == 0) ? 16 : (phase == 1) ? 69 : 0;
      snk_idle = (phase == 0) ? 69 : (phase == 1) ? 16 : 0;
      churn(230);
      drain();
      fill_store();
      churn(60);
      drain();
    end

    repeat (20) @(posedge clk_i);
    $display("covered %0d beats: %0d grants, %0d refused allocates on a full store, %0d clears",
             sb.beats, sb.grants, sb.refusals, sb.clears);
    $display("each of three stall patterns filled all %0d handles and churned at full",
             GRANT_SPAN);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("lowest_free_handle_allocator_top regression: pass");
    end else begin
      $display("lowest_free_handle_allocator_top regression: fail");
    end
    $finish;
  end

endmodule
